// ===== sv/fpa_pkg.sv =====
package fpa_pkg;

   localparam logic [3:0] KIND_ADD      = 4'd0;
   localparam logic [3:0] KIND_SUB      = 4'd1;
   localparam logic [3:0] KIND_MUL      = 4'd2;
   localparam logic [3:0] KIND_DIV      = 4'd3;
   localparam logic [3:0] KIND_GT       = 4'd4;
   localparam logic [3:0] KIND_LT       = 4'd5;
   localparam logic [3:0] KIND_GE       = 4'd6;
   localparam logic [3:0] KIND_LE       = 4'd7;
   localparam logic [3:0] KIND_EQ       = 4'd8;
   localparam logic [3:0] KIND_NE       = 4'd9;
   localparam logic [3:0] KIND_MIN      = 4'd10;
   localparam logic [3:0] KIND_MAX      = 4'd11;
   localparam logic [3:0] KIND_INC      = 4'd12;
   localparam logic [3:0] KIND_DEC      = 4'd13;
   localparam logic [3:0] KIND_TO_INT   = 4'd14;
   localparam logic [3:0] KIND_FROM_INT = 4'd15;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
   localparam logic [31:0] MIN32 = 32'h8000_0000;

   // travels alongside the datapath through every stage
   typedef struct packed {
      logic        valid;
      logic [3:0]  kind;
      logic        neg;
      logic [31:0] res;
      logic        cmp;
      logic [1:0]  status;
   } ctl_type;

endpackage

// ===== sv/fpa_front.sv =====
module fpa_front #(
   parameter int unsigned F = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                req_valid,
   input  logic [3:0]          req_kind,
   input  logic signed [31:0]  req_operand_a,
   input  logic signed [31:0]  req_operand_b,
   output fpa_pkg::ctl_type    ctl_o,
   output logic [63:0]         prod_o,
   output logic [32+F-1:0]     num_o,
   output logic [31:0]         den_o
);
   import fpa_pkg::*;

   localparam int unsigned NW = 32 + F;

   ctl_type     ctl_a_in, ctl_a_ff, ctl_b_ff;
   logic [31:0] mag_a_in, mag_b_in, mag_a_ff, mag_b_ff;
   logic [63:0] prod_ff;
   logic [NW-1:0] num_ff;
   logic [31:0] den_ff;
   logic [32:0] sum, diff;
   logic [F:0]  top_bits;
   logic        lt, eq;

   always_comb begin
      sum      = {req_operand_a[31], req_operand_a} + {req_operand_b[31], req_operand_b};
      diff     = {req_operand_a[31], req_operand_a} - {req_operand_b[31], req_operand_b};
      top_bits = req_operand_a[31 -: F+1];
      lt       = req_operand_a < req_operand_b;
      eq       = req_operand_a == req_operand_b;
      mag_a_in = req_operand_a[31] ? 32'(-req_operand_a) : req_operand_a;
      mag_b_in = req_operand_b[31] ? 32'(-req_operand_b) : req_operand_b;
      ctl_a_in.valid  = req_valid;
      ctl_a_in.kind   = req_kind;
      ctl_a_in.neg    = req_operand_a[31] ^ req_operand_b[31];
      ctl_a_in.res    = '0;
      ctl_a_in.cmp    = 1'b0;
      ctl_a_in.status = ST_OK;
      unique case (req_kind)
         KIND_ADD: begin
            if (sum[32] != sum[31]) begin
               ctl_a_in.res    = sum[32] ? MIN32 : MAX32;
               ctl_a_in.status = ST_OVF;
            end else begin
               ctl_a_in.res = sum[31:0];
            end
         end
         KIND_SUB: begin
            if (diff[32] != diff[31]) begin
               ctl_a_in.res    = diff[32] ? MIN32 : MAX32;
               ctl_a_in.status = ST_OVF;
            end else begin
               ctl_a_in.res = diff[31:0];
            end
         end
         KIND_MUL: ctl_a_in.res = '0;
         KIND_DIV: begin
            if (req_operand_b == '0) begin
               ctl_a_in.res    = req_operand_a[31] ? MIN32 : MAX32;
               ctl_a_in.status = ST_DIV0;
            end
         end
         KIND_GT: ctl_a_in.cmp = !lt && !eq;
         KIND_LT: ctl_a_in.cmp = lt;
         KIND_GE: ctl_a_in.cmp = !lt;
         KIND_LE: ctl_a_in.cmp = lt || eq;
         KIND_EQ: ctl_a_in.cmp = eq;
         KIND_NE: ctl_a_in.cmp = !eq;
         KIND_MIN: ctl_a_in.res = lt ? req_operand_a : req_operand_b;
         KIND_MAX: ctl_a_in.res = (!lt && !eq) ? req_operand_a : req_operand_b;
         KIND_INC: begin
            if (req_operand_a == MAX32) ctl_a_in.status = ST_OVF;
            ctl_a_in.res = (req_operand_a == MAX32) ? MAX32 : 32'(req_operand_a + 32'sd1);
         end
         KIND_DEC: begin
            if (req_operand_a == MIN32) ctl_a_in.status = ST_OVF;
            ctl_a_in.res = (req_operand_a == MIN32) ? MIN32 : 32'(req_operand_a - 32'sd1);
         end
         KIND_TO_INT: ctl_a_in.res = req_operand_a >>> F;
         KIND_FROM_INT: begin
            // fits only when the bits shifted out all match the sign
            if ((&top_bits) || !(|top_bits)) begin
               ctl_a_in.res = req_operand_a <<< F;
            end else begin
               ctl_a_in.res    = req_operand_a[31] ? MIN32 : MAX32;
               ctl_a_in.status = ST_OVF;
            end
         end
         default: ctl_a_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
      end else if (advance) begin
         ctl_a_ff <= ctl_a_in;
         ctl_b_ff <= ctl_a_ff;
      end
      if (advance) begin
         mag_a_ff <= mag_a_in;
         mag_b_ff <= mag_b_in;
         prod_ff  <= 64'(mag_a_ff) * 64'(mag_b_ff);
         num_ff   <= {mag_a_ff, F'(0)};
         den_ff   <= mag_b_ff;
      end
   end

   assign ctl_o  = ctl_b_ff;
   assign prod_o = prod_ff;
   assign num_o  = num_ff;
   assign den_o  = den_ff;

endmodule

// ===== sv/fpa_div_cell.sv =====
module fpa_div_cell #(
   parameter int unsigned NW = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  fpa_pkg::ctl_type ctl_i,
   input  logic [63:0]      prod_i,
   input  logic [32:0]      rem_i,
   input  logic [NW-1:0]    num_i,
   input  logic [31:0]      den_i,
   output fpa_pkg::ctl_type ctl_o,
   output logic [63:0]      prod_o,
   output logic [32:0]      rem_o,
   output logic [NW-1:0]    num_o,
   output logic [31:0]      den_o
);
   import fpa_pkg::*;

   ctl_type       ctl_ff;
   logic [63:0]   prod_ff;
   logic [32:0]   rem_ff, rem_in, rem_sh;
   logic [NW-1:0] num_ff, num_in;
   logic [31:0]   den_ff;
   logic          fits;

   // one restoring step: next numerator bit in, quotient bit out at the bottom
   always_comb begin
      rem_sh = {rem_i[31:0], num_i[NW-1]};
      fits   = rem_sh >= {1'b0, den_i};
      rem_in = fits ? rem_sh - {1'b0, den_i} : rem_sh;
      num_in = {num_i[NW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_i;
      end
      if (advance) begin
         prod_ff <= prod_i;
         rem_ff  <= rem_in;
         num_ff  <= num_in;
         den_ff  <= den_i;
      end
   end

   assign ctl_o  = ctl_ff;
   assign prod_o = prod_ff;
   assign rem_o  = rem_ff;
   assign num_o  = num_ff;
   assign den_o  = den_ff;

endmodule

// ===== sv/fpa_back.sv =====
module fpa_back #(
   parameter int unsigned F = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  fpa_pkg::ctl_type   ctl_i,
   input  logic [63:0]        prod_i,
   input  logic [32:0]        rem_i,
   input  logic [32+F-1:0]    num_i,
   input  logic [31:0]        den_i,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_result_raw,
   output logic               rsp_compare_true,
   output logic [1:0]         rsp_status
);
   import fpa_pkg::*;

   logic        valid_ff;
   logic [31:0] res_ff, res_in;
   logic        cmp_ff;
   logic [1:0]  st_ff, st_in;
   logic [63:0] mag, lim;
   logic        round_up, ovf;

   always_comb begin
      round_up = {rem_i, 1'b0} >= {2'b00, den_i};
      if (ctl_i.kind == KIND_MUL) begin
         mag = (prod_i + (64'd1 << (F - 1))) >> F;
      end else begin
         mag = 64'(num_i) + 64'(round_up);
      end
      lim = ctl_i.neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      ovf = mag > lim;
      res_in = ctl_i.res;
      st_in  = ctl_i.status;
      if ((ctl_i.kind == KIND_MUL || ctl_i.kind == KIND_DIV) && ctl_i.status != ST_DIV0) begin
         if (ovf) begin
            res_in = ctl_i.neg ? MIN32 : MAX32;
            st_in  = ST_OVF;
         end else begin
            res_in = ctl_i.neg ? 32'(-mag[31:0]) : mag[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= ctl_i.valid;
      end
      if (advance) begin
         res_ff <= res_in;
         cmp_ff <= ctl_i.cmp;
         st_ff  <= st_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_raw   = res_ff;
   assign rsp_compare_true = cmp_ff;
   assign rsp_status       = st_ff;

endmodule

// ===== sv/fixed_point_alu.sv =====
// channel   ports                                         direction
// req       req_valid req_stall req_kind req_operand_a/b  in
// rsp       rsp_valid rsp_stall rsp_result_raw
//           rsp_compare_true rsp_status                   out
//
// one word accepted per cycle while rsp is not stalled; a word shows on rsp after the front, divider and back stages
// the divider chain produces one quotient bit per cell
// synchronous reset clears the control words of the stages, not the datapath
// a stalled result freezes the whole pipeline and raises req_stall
module fixed_point_alu #(
   parameter int unsigned FRACTION_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_kind,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_raw,
   output logic               rsp_compare_true,
   output logic [1:0]         rsp_status
);
   import fpa_pkg::*;

   localparam int unsigned NW = 32 + FRACTION_BITS;

   logic          advance;
   ctl_type       ctl_c  [0:NW];
   logic [63:0]   prod_c [0:NW];
   logic [32:0]   rem_c  [0:NW];
   logic [NW-1:0] num_c  [0:NW];
   logic [31:0]   den_c  [0:NW];

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign rem_c[0]  = '0;

   fpa_front #(.F(FRACTION_BITS)) u_front (
      .clock, .reset, .advance, .req_valid, .req_kind, .req_operand_a, .req_operand_b,
      .ctl_o(ctl_c[0]), .prod_o(prod_c[0]), .num_o(num_c[0]), .den_o(den_c[0])
   );

   for (genvar i = 0; i < NW; i++) begin : g_cell
      fpa_div_cell #(.NW(NW)) u_cell (
         .clock, .reset, .advance,
         .ctl_i(ctl_c[i]), .prod_i(prod_c[i]), .rem_i(rem_c[i]), .num_i(num_c[i]),
         .den_i(den_c[i]),
         .ctl_o(ctl_c[i+1]), .prod_o(prod_c[i+1]), .rem_o(rem_c[i+1]),
         .num_o(num_c[i+1]), .den_o(den_c[i+1])
      );
   end

   fpa_back #(.F(FRACTION_BITS)) u_back (
      .clock, .reset, .advance,
      .ctl_i(ctl_c[NW]), .prod_i(prod_c[NW]), .rem_i(rem_c[NW]), .num_i(num_c[NW]),
      .den_i(den_c[NW]),
      .rsp_valid, .rsp_result_raw, .rsp_compare_true, .rsp_status
   );

   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_true |-> rsp_status == ST_OK && rsp_result_raw == '0)
      else $error("comparison word carries a value or status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_OVF || rsp_status == ST_DIV0)
      else $error("undefined status code");

   a_div0_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DIV0 |-> rsp_result_raw == MAX32 || rsp_result_raw == MIN32)
      else $error("division by zero not saturated");

   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

endmodule
